// File: rtl/rrb_pkg.sv
// ----------------------------------------------------------------------------
// rrb_pkg
// constants, types and saturation helpers for the rational resampler biquad
// ----------------------------------------------------------------------------
package rrb_pkg;

  // word field widths
  localparam int SAMPLE_BITS  = 16;
  localparam int COEF_W       = 20;
  localparam int FRAC_BITS    = 16;
  localparam int DELAY_W      = 40;
  localparam int PROD_W       = COEF_W + SAMPLE_BITS;
  localparam int ACC_W        = DELAY_W + 2;

  // configuration register widths
  localparam int UP_W         = 6;
  localparam int DOWN_W       = 8;
  localparam int CHAN_W       = 2;
  localparam int CFG_IDX_W    = 4;

  // limits
  localparam int MAX_UP       = 32;
  localparam int MAX_CHANNELS = 2;
  localparam int CH_SLOTS     = 2;
  localparam int K_W          = (MAX_UP > 1) ? $clog2(MAX_UP) : 1;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UP    = 4'd0,
    REG_DOWN  = 4'd1,
    REG_CHANS = 4'd2,
    REG_B0    = 4'd3,
    REG_B1    = 4'd4,
    REG_B2    = 4'd5,
    REG_A1    = 4'd6,
    REG_A2    = 4'd7
  } reg_idx_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B0,
    ST_Y,
    ST_B1,
    ST_B2,
    ST_A1,
    ST_A2,
    ST_EMIT,
    ST_FLUSH
  } state_e;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      sat_sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (v < lo) begin
      sat_sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat_sample = v[SAMPLE_BITS-1:0];
    end
  endfunction

  function automatic logic signed [DELAY_W-1:0] sat_delay(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-DELAY_W+1){1'b0}}, {(DELAY_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      sat_delay = {1'b0, {(DELAY_W-1){1'b1}}};
    end else if (v < lo) begin
      sat_delay = {1'b1, {(DELAY_W-1){1'b0}}};
    end else begin
      sat_delay = v[DELAY_W-1:0];
    end
  endfunction

endpackage

// File: rtl/rational_resampler_biquad.sv
// ----------------------------------------------------------------------------
// rational_resampler_biquad
// L/M audio resampler: zero stuffing, per-channel biquad low-pass, decimation
// ----------------------------------------------------------------------------
// Each input word (sample plus channel) is followed by up_factor-1 zeros, and
// all of these values run through the transposed direct form II biquad kept
// for that channel (left/right state in stereo, channel 0 in mono). Every
// down_factor-th filtered value of a channel, counted by a per-channel phase
// that survives across input words, leaves as an output word; last_o marks
// the final output word caused by an input word. All filter math goes through
// one registered 20x16 multiplier driven by a small sequencer, so the block
// takes one input word at a time: the stuffed-in sample passes through the
// states B0, Y, B1, B2, A1 and A2, each stuffed zero through Y, B2, A1 and
// A2, each emitted word through EMIT and the wrap-up through FLUSH, after the
// IDLE state in which the word is taken; EMIT and FLUSH can wait while the
// output side holds off out_ready_i. The output register lets the
// sequencer go on while a finished word waits to be taken. Configuration
// writes are always taken (cfg_ready_o is tied high) and belong in idle time.
// ----------------------------------------------------------------------------
module rational_resampler_biquad (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [rrb_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [rrb_pkg::COEF_W-1:0]             cfg_data_i,
  // input words
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [rrb_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic                                   channel_in_i,
  // output words
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [rrb_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic                                   channel_out_o,
  output logic                                   last_o
);
  import rrb_pkg::*;

  // configuration registers
  logic [UP_W-1:0]           up_q;
  logic [DOWN_W-1:0]         down_q;
  logic [CHAN_W-1:0]         chans_q;
  logic signed [COEF_W-1:0]  b0_q, b1_q, b2_q, a1_q, a2_q;

  // sequencer
  state_e                    state_q, state_d;
  logic [K_W-1:0]            k_q;
  logic                      ch_q;

  // filter state per channel
  logic signed [DELAY_W-1:0] d1_q [CH_SLOTS];
  logic signed [DELAY_W-1:0] d2_q [CH_SLOTS];
  logic [DOWN_W-1:0]         phase_q [CH_SLOTS];

  // working registers
  logic signed [SAMPLE_BITS-1:0] x_q, y_q, pend_y_q, out_y_q;
  logic signed [PROD_W-1:0]      prod_q, t1_q, t2_q;
  logic                          pend_v_q, out_v_q, out_ch_q, out_last_q;

  // effective settings after clamping
  logic [UP_W-1:0]   l_eff;
  logic [DOWN_W-1:0] m_eff;
  logic              stereo;
  logic              first_step, last_step;

  always_comb begin
    if (up_q == '0) begin
      l_eff = UP_W'(1);
    end else if (up_q > UP_W'(MAX_UP)) begin
      l_eff = UP_W'(MAX_UP);
    end else begin
      l_eff = up_q;
    end
    m_eff  = (down_q == '0) ? DOWN_W'(1) : down_q;
    stereo = (MAX_CHANNELS > 1) && (chans_q >= CHAN_W'(2));
  end

  assign first_step = (k_q == '0);
  assign last_step  = (UP_W'(k_q) == (l_eff - UP_W'(1)));

  // shared multiplier, product registered every cycle
  logic signed [COEF_W-1:0]      mul_a;
  logic signed [SAMPLE_BITS-1:0] mul_b;
  logic signed [PROD_W-1:0]      mul_a_ext, mul_b_ext, prod_d;

  assign mul_a_ext = {{SAMPLE_BITS{mul_a[COEF_W-1]}}, mul_a};
  assign mul_b_ext = {{COEF_W{mul_b[SAMPLE_BITS-1]}}, mul_b};
  assign prod_d    = mul_a_ext * mul_b_ext;

  // output value: round half up, then saturate
  logic signed [ACC_W-1:0]       acc, acc_rnd;
  logic signed [SAMPLE_BITS-1:0] y_d;
  logic signed [PROD_W-1:0]      b0x;

  assign b0x     = first_step ? prod_q : '0;
  assign acc     = ACC_W'(b0x) + ACC_W'(d1_q[ch_q]);
  assign acc_rnd = acc + (ACC_W'(1) <<< (FRAC_BITS - 1));
  assign y_d     = sat_sample(acc_rnd >>> FRAC_BITS);

  // delay updates, d1 uses the old d2
  logic signed [DELAY_W-1:0] d1_d, d2_d;
  assign d1_d = sat_delay(ACC_W'(t1_q) - ACC_W'(prod_q) + ACC_W'(d2_q[ch_q]));
  assign d2_d = sat_delay(ACC_W'(t2_q) - ACC_W'(prod_q));

  // decimation phase
  logic [DOWN_W-1:0] phase_inc;
  logic              hit;
  assign phase_inc = phase_q[ch_q] + DOWN_W'(1);
  assign hit       = (phase_inc >= m_eff) || (phase_inc == '0);

  logic out_free;
  assign out_free = !out_v_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_B0;
      ST_B0:    state_d = ST_Y;
      ST_Y:     state_d = first_step ? ST_B1 : ST_B2;
      ST_B1:    state_d = ST_B2;
      ST_B2:    state_d = ST_A1;
      ST_A1:    state_d = ST_A2;
      ST_A2: begin
        if (hit) begin
          state_d = ST_EMIT;
        end else begin
          state_d = last_step ? ST_FLUSH : ST_Y;
        end
      end
      ST_EMIT: begin
        if (!pend_v_q || out_free) begin
          state_d = last_step ? ST_FLUSH : ST_Y;
        end
      end
      ST_FLUSH: if (!pend_v_q || out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  logic emit_go, flush_go, step_adv, out_load;
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    emit_go    = (state_q == ST_EMIT)  && (!pend_v_q || out_free);
    flush_go   = (state_q == ST_FLUSH) && (!pend_v_q || out_free);
    step_adv   = (emit_go || ((state_q == ST_A2) && !hit)) && !last_step;
    out_load   = (emit_go || flush_go) && pend_v_q;
    mul_a      = b0_q;
    mul_b      = x_q;
    unique case (state_q)
      ST_B0: begin
        mul_a = b0_q;
        mul_b = x_q;
      end
      ST_Y: begin
        mul_a = b1_q;
        mul_b = x_q;
      end
      ST_B1: begin
        mul_a = b2_q;
        mul_b = x_q;
      end
      ST_B2: begin
        mul_a = a1_q;
        mul_b = y_q;
      end
      ST_A1: begin
        mul_a = a2_q;
        mul_b = y_q;
      end
      default: begin
        mul_a = b0_q;
        mul_b = x_q;
      end
    endcase
  end

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q    <= UP_W'(1);
      down_q  <= DOWN_W'(1);
      chans_q <= CHAN_W'(1);
      b0_q    <= COEF_W'(1) <<< FRAC_BITS;
      b1_q    <= '0;
      b2_q    <= '0;
      a1_q    <= '0;
      a2_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_UP:    up_q    <= cfg_data_i[UP_W-1:0];
        REG_DOWN:  down_q  <= cfg_data_i[DOWN_W-1:0];
        REG_CHANS: chans_q <= cfg_data_i[CHAN_W-1:0];
        REG_B0:    b0_q    <= cfg_data_i;
        REG_B1:    b1_q    <= cfg_data_i;
        REG_B2:    b2_q    <= cfg_data_i;
        REG_A1:    a1_q    <= cfg_data_i;
        REG_A2:    a2_q    <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      k_q        <= '0;
      ch_q       <= 1'b0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_ch_q   <= 1'b0;
      out_last_q <= 1'b0;
      for (int i = 0; i < CH_SLOTS; i++) begin
        d1_q[i]    <= '0;
        d2_q[i]    <= '0;
        phase_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if ((state_q == ST_IDLE) && in_valid_i) begin
        k_q  <= '0;
        ch_q <= stereo ? channel_in_i : 1'b0;
      end else if (step_adv) begin
        k_q <= k_q + K_W'(1);
      end
      if (state_q == ST_A1) begin
        d1_q[ch_q] <= d1_d;
      end
      if (state_q == ST_A2) begin
        d2_q[ch_q]    <= d2_d;
        phase_q[ch_q] <= hit ? '0 : phase_inc;
      end
      if (emit_go) begin
        pend_v_q <= 1'b1;
      end else if (flush_go) begin
        pend_v_q <= 1'b0;
      end
      if (out_load) begin
        out_v_q    <= 1'b1;
        out_ch_q   <= ch_q;
        out_last_q <= (state_q == ST_FLUSH);
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // datapath words
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if ((state_q == ST_IDLE) && in_valid_i) begin
      x_q <= sample_in_i;
    end
    if (state_q == ST_Y) begin
      y_q <= y_d;
      if (!first_step) begin
        t1_q <= '0;
      end
    end
    if (state_q == ST_B1) begin
      t1_q <= prod_q;
    end
    if (state_q == ST_B2) begin
      t2_q <= first_step ? prod_q : '0;
    end
    if (emit_go) begin
      pend_y_q <= y_q;
    end
    if (out_load) begin
      out_y_q <= pend_y_q;
    end
  end

  assign out_valid_o   = out_v_q;
  assign sample_out_o  = out_y_q;
  assign channel_out_o = out_ch_q;
  assign last_o        = out_last_q;

  // no word may be left pending when a new input word can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("pending word left behind at idle");

  // the step counter stays inside the stuffing factor while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (UP_W'(k_q) < l_eff))
    else $error("step counter beyond stuffing factor");

  // wrap-up of an item moves the pending word out flagged as last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FLUSH) && pend_v_q && out_free) |=> (out_valid_o && last_o))
    else $error("final word of an item not flagged last");

endmodule
